FILE: rtl/ksm_pkg.sv
package ksm_pkg;

	// Field widths of the stream items
	localparam int FUNC_W     = 2;
	localparam int KEY_W      = 9;
	localparam int SLOT_W     = 6;
	localparam int POS_W      = 3;
	localparam int SEQLEN_W   = 4;
	localparam int ACT_W      = 6;
	localparam int STATUS_W   = 2;

	localparam int IN_FIELDS_W = KEY_W + SLOT_W + POS_W + SEQLEN_W + ACT_W;
	localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_DATA_W  = ((ACT_W + 7) / 8) * 8;

	// tdata bit offsets, lowest field first
	localparam int KEY_LSB    = 0;
	localparam int SLOT_LSB   = KEY_LSB + KEY_W;
	localparam int POS_LSB    = SLOT_LSB + SLOT_W;
	localparam int SEQLEN_LSB = POS_LSB + POS_W;
	localparam int ACT_LSB    = SEQLEN_LSB + SEQLEN_W;

	// Function codes
	localparam logic [FUNC_W-1:0] FUNC_KEY   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_NONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_PREFIX  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MATCH   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_WRITTEN = 2'd3;

	typedef struct packed {
		logic                capture;
		logic                append;
		logic                retry;
		logic                flush;
		logic                scan_start;
		logic                tbl_write;
		logic                tbl_clear;
		logic                res_load;
		logic [STATUS_W-1:0] res_status;
		logic                out_load;
	} ksm_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              wr_ok;
		logic              clr_ok;
		logic              scan_done;
		logic              scan_hit;
		logic              scan_full;
		logic              multi;
	} ksm_sts_t;

endpackage

FILE: rtl/ksm_ctrl.sv
module ksm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ksm_pkg::ksm_sts_t sts,
	output ksm_pkg::ksm_cmd_t cmd
);
	import ksm_pkg::*;

	localparam logic [1:0] S_IDLE     = 2'd0;
	localparam logic [1:0] S_DISPATCH = 2'd1;
	localparam logic [1:0] S_SCAN     = 2'd2;
	localparam logic [1:0] S_RESULT   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_vld_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_vld_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.func)
					FUNC_KEY: begin
						cmd.append     = 1'b1;
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end
					FUNC_WRITE: begin
						cmd.tbl_write  = sts.wr_ok;
						cmd.res_load   = 1'b1;
						cmd.res_status = sts.wr_ok ? ST_WRITTEN : ST_NONE;
						state_d        = S_RESULT;
					end
					FUNC_CLEAR: begin
						cmd.tbl_clear  = sts.clr_ok;
						cmd.res_load   = 1'b1;
						cmd.res_status = sts.clr_ok ? ST_WRITTEN : ST_NONE;
						state_d        = S_RESULT;
					end
					default: begin
						cmd.res_load   = 1'b1;
						cmd.res_status = ST_NONE;
						state_d        = S_RESULT;
					end
				endcase
			end
			S_SCAN: begin
				if (sts.scan_done) begin
					if (sts.scan_hit) begin
						cmd.res_load   = 1'b1;
						cmd.res_status = sts.scan_full ? ST_MATCH : ST_PREFIX;
						state_d        = S_RESULT;
					end else if (sts.multi) begin
						// retry the key alone
						cmd.retry      = 1'b1;
						cmd.scan_start = 1'b1;
					end else begin
						cmd.flush      = 1'b1;
						cmd.res_load   = 1'b1;
						cmd.res_status = ST_NONE;
						state_d        = S_RESULT;
					end
				end
			end
			S_RESULT: begin
				if (!out_vld_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_vld_q <= 1'b1;
			else if (out_ready)
				out_vld_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/ksm_datapath.sv
module ksm_datapath #(
	parameter int MAX_SEQ   = 8,
	parameter int NUM_SLOTS = 64,
	parameter int NUM_ACTS  = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [ksm_pkg::IN_DATA_W-1:0]    in_data,
	input  logic [ksm_pkg::FUNC_W-1:0]       in_user,
	output logic [ksm_pkg::OUT_DATA_W-1:0]   out_data,
	output logic [ksm_pkg::STATUS_W-1:0]     out_user,
	input  ksm_pkg::ksm_cmd_t                cmd,
	output ksm_pkg::ksm_sts_t                sts
);
	import ksm_pkg::*;

	localparam int CNT_W = $clog2(MAX_SEQ + 1);
	localparam int LANE_W = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1;
	localparam int IDX_W = $clog2(NUM_SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

	// Captured item
	logic [FUNC_W-1:0]   func_q;
	logic [KEY_W-1:0]    key_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [POS_W-1:0]    pos_q;
	logic [SEQLEN_W-1:0] seqlen_q;
	logic [ACT_W-1:0]    act_q;

	// Key buffer
	logic [KEY_W-1:0] buf_q [MAX_SEQ];
	logic [CNT_W-1:0] cnt_q;

	// Binding table
	logic [KEY_W-1:0] keys_mem [NUM_SLOTS][MAX_SEQ];
	logic [CNT_W-1:0] len_mem [NUM_SLOTS];
	logic [ACT_W-1:0] act_mem [NUM_SLOTS];
	logic             slot_vld_q [NUM_SLOTS];

	// Scan engine
	logic             busy_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             eval_vld_s1;
	logic             eval_last_s1;
	logic [KEY_W-1:0] row_s1 [MAX_SEQ];
	logic [CNT_W-1:0] len_s1;
	logic [ACT_W-1:0] act_s1;
	logic             vld_s1;

	logic [MAX_SEQ-1:0] lane_ok;
	logic               hit;
	logic               scan_done;

	logic [IDX_W-1:0]  wr_idx;
	logic [LANE_W-1:0] wr_lane;
	logic [CNT_W-1:0]  wr_len;

	logic [STATUS_W-1:0] res_status_q;
	logic [ACT_W-1:0]    res_act_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [ACT_W-1:0]    out_act_q;

	assign wr_idx  = IDX_W'(slot_q);
	assign wr_lane = LANE_W'(pos_q);
	assign wr_len  = (32'(seqlen_q) > MAX_SEQ) ? CNT_W'(MAX_SEQ) : CNT_W'(seqlen_q);

	always_comb begin
		for (int k = 0; k < MAX_SEQ; k++)
			lane_ok[k] = (CNT_W'(k) >= cnt_q) || (buf_q[k] == row_s1[k]);
	end

	assign hit = vld_s1 && (len_s1 != '0) && (cnt_q <= len_s1) && (&lane_ok);
	assign scan_done = eval_vld_s1 && (hit || eval_last_s1);

	assign sts.func      = func_q;
	assign sts.wr_ok     = (32'(slot_q) < NUM_SLOTS) && (32'(pos_q) < MAX_SEQ)
		&& (32'(act_q) < NUM_ACTS);
	assign sts.clr_ok    = (32'(slot_q) < NUM_SLOTS);
	assign sts.scan_done = scan_done;
	assign sts.scan_hit  = hit;
	assign sts.scan_full = (cnt_q == len_s1);
	assign sts.multi     = (cnt_q > CNT_W'(1));

	assign out_user = out_status_q;
	assign out_data = OUT_DATA_W'(out_act_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q   <= in_user;
			key_q    <= in_data[KEY_LSB +: KEY_W];
			slot_q   <= in_data[SLOT_LSB +: SLOT_W];
			pos_q    <= in_data[POS_LSB +: POS_W];
			seqlen_q <= in_data[SEQLEN_LSB +: SEQLEN_W];
			act_q    <= in_data[ACT_LSB +: ACT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			if (32'(cnt_q) >= MAX_SEQ)
				buf_q[0] <= key_q;
			else
				buf_q[cnt_q[LANE_W-1:0]] <= key_q;
		end else if (cmd.retry) begin
			buf_q[0] <= key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.append) begin
			// empty a full buffer before appending
			if (32'(cnt_q) >= MAX_SEQ)
				cnt_q <= CNT_W'(1);
			else
				cnt_q <= cnt_q + CNT_W'(1);
		end else if (cmd.retry) begin
			cnt_q <= CNT_W'(1);
		end else if (cmd.flush) begin
			cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tbl_write) begin
			keys_mem[wr_idx][wr_lane] <= key_q;
			len_mem[wr_idx]           <= wr_len;
			act_mem[wr_idx]           <= act_q;
		end
		if (busy_q) begin
			row_s1 <= keys_mem[rd_idx_q];
			len_s1 <= len_mem[rd_idx_q];
			act_s1 <= act_mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SLOTS; s++)
				slot_vld_q[s] <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			if (cmd.tbl_write)
				slot_vld_q[wr_idx] <= 1'b1;
			else if (cmd.tbl_clear)
				slot_vld_q[wr_idx] <= 1'b0;
			if (busy_q)
				vld_s1 <= slot_vld_q[rd_idx_q];
		end
	end

	// Walk the slots in priority order, one read per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			rd_idx_q     <= '0;
			eval_vld_s1  <= 1'b0;
			eval_last_s1 <= 1'b0;
		end else if (cmd.scan_start) begin
			busy_q      <= 1'b1;
			rd_idx_q    <= '0;
			eval_vld_s1 <= 1'b0;
		end else if (scan_done) begin
			busy_q      <= 1'b0;
			eval_vld_s1 <= 1'b0;
		end else begin
			eval_vld_s1 <= busy_q;
			if (busy_q) begin
				eval_last_s1 <= (rd_idx_q == LAST_IDX);
				rd_idx_q     <= rd_idx_q + IDX_W'(1);
				if (rd_idx_q == LAST_IDX)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_act_q    <= (cmd.res_status == ST_MATCH) ? act_s1 : '0;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_act_q    <= res_act_q;
		end
	end

endmodule

FILE: rtl/key_sequence_matcher_core.sv
// Key sequence matcher: one result transfer per input transfer.
// Table write or clear: the result is registered in DISPATCH, sent from RESULT.
// Key press: one table row read per cycle in slot order until the first hit or
// the last slot; a miss with more than one key buffered retries the key alone.
// The next input is taken only once the result has moved to the output register.
// arst_n empties the key buffer and marks every slot empty at once.
module key_sequence_matcher_core #(
	parameter int MAX_SEQ   = 8,
	parameter int NUM_SLOTS = 64,
	parameter int NUM_ACTS  = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// key_code[8:0], slot[14:9], position[17:15], seq_len[21:18],
	// action_id[27:22], zero fill above
	input  logic [ksm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// func[1:0]
	input  logic [ksm_pkg::FUNC_W-1:0]      s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// matched_action[5:0], zero fill above
	output logic [ksm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// status[1:0]
	output logic [ksm_pkg::STATUS_W-1:0]    m_axis_tuser
);
	import ksm_pkg::*;

	ksm_cmd_t cmd;
	ksm_sts_t sts;

	ksm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ksm_datapath #(
		.MAX_SEQ   (MAX_SEQ),
		.NUM_SLOTS (NUM_SLOTS),
		.NUM_ACTS  (NUM_ACTS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (s_axis_tdata),
		.in_user  (s_axis_tuser),
		.out_data (m_axis_tdata),
		.out_user (m_axis_tuser),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule
